/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check under reset gating
`define MLFQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mlfq assertion failed");

// check that also holds during reset
`define MLFQ_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("mlfq assertion failed");

`endif

/* hw/rtl/mlfq_pkg.sv */
package mlfq_pkg;

   localparam int TABLE_ENTRIES_DEF = 64;
   localparam int LEVELS            = 5;

   localparam logic [15:0] QUANTUM_RESET = 16'd10;

   // operation codes
   localparam logic OP_SUBMIT   = 1'b0;
   localparam logic OP_DISPATCH = 1'b1;

   // result status codes
   localparam logic [2:0] STATUS_ACCEPTED = 3'd0;
   localparam logic [2:0] STATUS_FULL     = 3'd1;
   localparam logic [2:0] STATUS_IDLE     = 3'd2;
   localparam logic [2:0] STATUS_PARTIAL  = 3'd3;
   localparam logic [2:0] STATUS_DONE     = 3'd4;

   // level codes
   localparam logic [2:0] LEVEL_RT    = 3'd0;
   localparam logic [2:0] LEVEL_LOW   = 3'd1;
   localparam logic [2:0] LEVEL_MID   = 3'd2;
   localparam logic [2:0] LEVEL_HIGH  = 3'd3;
   localparam logic [2:0] LEVEL_RR    = 3'd4;

   localparam logic signed [8:0] PRIO_STEP = 9'sd10;
   localparam logic signed [8:0] PRIO_CAP  = 9'sd31;

   typedef struct packed {
      logic              op;
      logic [15:0]       id;
      logic signed [7:0] prio;
      logic [15:0]       burst;
      logic [2:0]        band;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ALLOC_WAIT,
      ST_WRITE,
      ST_FETCH_WAIT,
      ST_PLACE,
      ST_WALK,
      ST_WALK_WAIT,
      ST_LINK,
      ST_LINK_PREV,
      ST_EMIT
   } seq_state_type;

   // priority band to level
   function automatic logic [2:0] band_of(input logic signed [7:0] p);
      logic [2:0] b;
      if (p inside {[-8'sd10:-8'sd1]}) begin
         b = LEVEL_RT;
      end else if (p inside {[8'sd1:8'sd10]}) begin
         b = LEVEL_LOW;
      end else if (p inside {[8'sd11:8'sd20]}) begin
         b = LEVEL_MID;
      end else if (p inside {[8'sd21:8'sd30]}) begin
         b = LEVEL_HIGH;
      end else begin
         b = LEVEL_RR;
      end
      return b;
   endfunction

endpackage

/* hw/rtl/mlfq_front.sv */
module mlfq_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_operation,
   input  logic [15:0]          req_process_id,
   input  logic signed [7:0]    req_start_priority,
   input  logic [15:0]          req_burst_time,
   output logic                 item_valid,
   output mlfq_pkg::item_type   item,
   input  logic                 item_pop
);

   mlfq_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   mlfq_pkg::item_type new_item;

   // classify the incoming beat
   always_comb begin
      new_item.op    = req_operation;
      new_item.id    = req_process_id;
      new_item.prio  = req_start_priority;
      new_item.burst = req_burst_time;
      new_item.band  = mlfq_pkg::band_of(req_start_priority);
   end

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ item_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

/* hw/rtl/mlfq_back.sv */
`include "assert_macros.svh"

module mlfq_back #(
   parameter int TABLE_ENTRIES = mlfq_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  mlfq_pkg::item_type   item,
   output logic                 item_pop,
   input  logic                 csr_we,
   input  logic [15:0]          csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_status,
   output logic [15:0]          rsp_run_id,
   output logic [2:0]           rsp_level,
   output logic signed [7:0]    rsp_new_priority,
   output logic [15:0]          rsp_work_left,
   output logic [31:0]          rsp_time_now
);

   localparam int IdxW = $clog2(TABLE_ENTRIES);
   localparam int PtrW = IdxW + 1;
   localparam logic [PtrW-1:0] NONE = PtrW'(TABLE_ENTRIES);

   // entry table
   logic [15:0]       id_mem   [TABLE_ENTRIES];
   logic signed [7:0] prio_mem [TABLE_ENTRIES];
   logic [15:0]       rem_mem  [TABLE_ENTRIES];
   logic [PtrW-1:0]   next_mem [TABLE_ENTRIES];

   logic [15:0]       rd_id_ff;
   logic signed [7:0] rd_prio_ff;
   logic [15:0]       rd_rem_ff;
   logic [PtrW-1:0]   rd_next_ff;
   logic [IdxW-1:0]   rd_addr;

   logic              tab_we;
   logic              id_we;
   logic [15:0]       id_wd;
   logic signed [7:0] prio_wd;
   logic [15:0]       rem_wd;
   logic              next_we;
   logic [IdxW-1:0]   next_wa;
   logic [PtrW-1:0]   next_wd;

   // control state
   mlfq_pkg::seq_state_type state_ff, state_in;
   logic [PtrW-1:0] head_ff [mlfq_pkg::LEVELS];
   logic [PtrW-1:0] head_in [mlfq_pkg::LEVELS];
   logic [PtrW-1:0] tail_ff [mlfq_pkg::LEVELS];
   logic [PtrW-1:0] tail_in [mlfq_pkg::LEVELS];
   logic [PtrW-1:0] free_ff, free_in;
   logic [PtrW-1:0] fill_ff, fill_in;
   logic [31:0]     time_ff, time_in;
   logic [15:0]     quantum_ff, quantum_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // working registers
   mlfq_pkg::item_type op_ff, op_in;
   logic [IdxW-1:0]    idx_ff, idx_in;
   logic [2:0]         band_ff, band_in;
   logic signed [7:0]  key_ff, key_in;
   logic [PtrW-1:0]    prev_ff, prev_in;
   logic [PtrW-1:0]    cur_ff, cur_in;
   logic [2:0]         res_status_ff, res_status_in;
   logic [15:0]        res_id_ff, res_id_in;
   logic [2:0]         res_level_ff, res_level_in;
   logic signed [7:0]  res_prio_ff, res_prio_in;
   logic [15:0]        res_left_ff, res_left_in;

   logic [2:0]         rsp_status_ff;
   logic [15:0]        rsp_run_id_ff;
   logic [2:0]         rsp_level_ff;
   logic signed [7:0]  rsp_prio_ff;
   logic [15:0]        rsp_left_ff;
   logic [31:0]        rsp_time_ff;

   logic               found;
   logic [2:0]         pick_lv;
   logic               out_free;
   logic               table_full;
   logic               load_out;
   logic signed [8:0]  bumped;
   logic signed [7:0]  new_prio;

   // first non-empty level
   always_comb begin
      found   = 1'b0;
      pick_lv = mlfq_pkg::LEVEL_RT;
      for (int i = mlfq_pkg::LEVELS - 1; i >= 0; i--) begin
         if (head_ff[i] != NONE) begin
            found   = 1'b1;
            pick_lv = 3'(i);
         end
      end
   end

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign table_full = (free_ff == NONE) && (fill_ff == NONE);
   assign bumped     = 9'(rd_prio_ff) + mlfq_pkg::PRIO_STEP;
   assign new_prio   = (bumped > mlfq_pkg::PRIO_CAP) ? 8'(mlfq_pkg::PRIO_CAP) : 8'(bumped);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mlfq_pkg::ST_IDLE: begin
            if (item_valid) state_in = mlfq_pkg::ST_DECODE;
         end
         mlfq_pkg::ST_DECODE: begin
            if (op_ff.op == mlfq_pkg::OP_SUBMIT) begin
               if (table_full) state_in = mlfq_pkg::ST_EMIT;
               else if (free_ff != NONE) state_in = mlfq_pkg::ST_ALLOC_WAIT;
               else state_in = mlfq_pkg::ST_WRITE;
            end else begin
               if (found) state_in = mlfq_pkg::ST_FETCH_WAIT;
               else state_in = mlfq_pkg::ST_EMIT;
            end
         end
         mlfq_pkg::ST_ALLOC_WAIT: state_in = mlfq_pkg::ST_WRITE;
         mlfq_pkg::ST_WRITE:      state_in = mlfq_pkg::ST_PLACE;
         mlfq_pkg::ST_FETCH_WAIT: begin
            if (band_ff != mlfq_pkg::LEVEL_RT && rd_rem_ff > quantum_ff) begin
               state_in = mlfq_pkg::ST_PLACE;
            end else begin
               state_in = mlfq_pkg::ST_EMIT;
            end
         end
         mlfq_pkg::ST_PLACE: begin
            if (band_ff == mlfq_pkg::LEVEL_RT || band_ff == mlfq_pkg::LEVEL_RR) begin
               state_in = mlfq_pkg::ST_LINK;
            end else begin
               state_in = mlfq_pkg::ST_WALK;
            end
         end
         mlfq_pkg::ST_WALK: begin
            if (cur_ff == NONE) state_in = mlfq_pkg::ST_LINK;
            else state_in = mlfq_pkg::ST_WALK_WAIT;
         end
         mlfq_pkg::ST_WALK_WAIT: begin
            if (rd_prio_ff <= key_ff) state_in = mlfq_pkg::ST_WALK;
            else state_in = mlfq_pkg::ST_LINK;
         end
         mlfq_pkg::ST_LINK: begin
            if (prev_ff == NONE) state_in = mlfq_pkg::ST_EMIT;
            else state_in = mlfq_pkg::ST_LINK_PREV;
         end
         mlfq_pkg::ST_LINK_PREV: state_in = mlfq_pkg::ST_EMIT;
         mlfq_pkg::ST_EMIT: begin
            if (out_free) state_in = mlfq_pkg::ST_IDLE;
         end
         default: state_in = mlfq_pkg::ST_IDLE;
      endcase
   end

   // datapath and table control
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_in       = free_ff;
      fill_in       = fill_ff;
      time_in       = time_ff;
      quantum_in    = csr_we ? csr_wdata : quantum_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      band_in       = band_ff;
      key_in        = key_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_level_in  = res_level_ff;
      res_prio_in   = res_prio_ff;
      res_left_in   = res_left_ff;
      item_pop      = 1'b0;
      load_out      = 1'b0;
      rd_addr       = cur_ff[IdxW-1:0];
      tab_we        = 1'b0;
      id_we         = 1'b0;
      id_wd         = op_ff.id;
      prio_wd       = op_ff.prio;
      rem_wd        = op_ff.burst;
      next_we       = 1'b0;
      next_wa       = idx_ff;
      next_wd       = cur_ff;
      case (state_ff)
         mlfq_pkg::ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               op_in    = item;
            end
         end
         mlfq_pkg::ST_DECODE: begin
            if (op_ff.op == mlfq_pkg::OP_SUBMIT) begin
               band_in       = op_ff.band;
               key_in        = op_ff.prio;
               res_status_in = table_full ? mlfq_pkg::STATUS_FULL
                                          : mlfq_pkg::STATUS_ACCEPTED;
               res_id_in     = op_ff.id;
               res_level_in  = op_ff.band;
               res_prio_in   = op_ff.prio;
               res_left_in   = op_ff.burst;
               if (!table_full) begin
                  if (free_ff != NONE) begin
                     idx_in  = free_ff[IdxW-1:0];
                     rd_addr = free_ff[IdxW-1:0];
                  end else begin
                     idx_in  = fill_ff[IdxW-1:0];
                     fill_in = fill_ff + 1'b1;
                  end
               end
            end else if (found) begin
               band_in = pick_lv;
               idx_in  = head_ff[pick_lv][IdxW-1:0];
               rd_addr = head_ff[pick_lv][IdxW-1:0];
            end else begin
               time_in       = time_ff + 32'd1;
               res_status_in = mlfq_pkg::STATUS_IDLE;
               res_id_in     = '0;
               res_level_in  = mlfq_pkg::LEVEL_RT;
               res_prio_in   = '0;
               res_left_in   = '0;
            end
         end
         mlfq_pkg::ST_ALLOC_WAIT: begin
            free_in = rd_next_ff;
         end
         mlfq_pkg::ST_WRITE: begin
            tab_we = 1'b1;
            id_we  = 1'b1;
         end
         mlfq_pkg::ST_FETCH_WAIT: begin
            // unlink the head
            head_in[band_ff] = rd_next_ff;
            if (rd_next_ff == NONE) tail_in[band_ff] = NONE;
            res_id_in    = rd_id_ff;
            res_level_in = band_ff;
            if (band_ff != mlfq_pkg::LEVEL_RT && rd_rem_ff > quantum_ff) begin
               time_in       = time_ff + 32'(quantum_ff);
               rem_wd        = rd_rem_ff - quantum_ff;
               prio_wd       = (band_ff == mlfq_pkg::LEVEL_RR) ? rd_prio_ff : new_prio;
               tab_we        = 1'b1;
               key_in        = prio_wd;
               band_in       = mlfq_pkg::band_of(prio_wd);
               res_status_in = mlfq_pkg::STATUS_PARTIAL;
               res_prio_in   = prio_wd;
               res_left_in   = rem_wd;
            end else begin
               // completed, back onto the free chain
               time_in       = time_ff + 32'(rd_rem_ff);
               rem_wd        = '0;
               prio_wd       = rd_prio_ff;
               tab_we        = 1'b1;
               next_we       = 1'b1;
               next_wd       = free_ff;
               free_in       = {1'b0, idx_ff};
               res_status_in = mlfq_pkg::STATUS_DONE;
               res_prio_in   = rd_prio_ff;
               res_left_in   = '0;
            end
         end
         mlfq_pkg::ST_PLACE: begin
            if (band_ff == mlfq_pkg::LEVEL_RT || band_ff == mlfq_pkg::LEVEL_RR) begin
               prev_in = tail_ff[band_ff];
               cur_in  = NONE;
            end else begin
               prev_in = NONE;
               cur_in  = head_ff[band_ff];
            end
         end
         mlfq_pkg::ST_WALK: begin
            rd_addr = cur_ff[IdxW-1:0];
         end
         mlfq_pkg::ST_WALK_WAIT: begin
            if (rd_prio_ff <= key_ff) begin
               prev_in = cur_ff;
               cur_in  = rd_next_ff;
            end
         end
         mlfq_pkg::ST_LINK: begin
            next_we = 1'b1;
            next_wd = cur_ff;
            if (cur_ff == NONE) tail_in[band_ff] = {1'b0, idx_ff};
            if (prev_ff == NONE) head_in[band_ff] = {1'b0, idx_ff};
         end
         mlfq_pkg::ST_LINK_PREV: begin
            next_we = 1'b1;
            next_wa = prev_ff[IdxW-1:0];
            next_wd = {1'b0, idx_ff};
         end
         mlfq_pkg::ST_EMIT: begin
            load_out = out_free;
         end
         default: begin
         end
      endcase
   end

   // output slot handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlfq_pkg::ST_IDLE;
         head_ff      <= '{default: NONE};
         tail_ff      <= '{default: NONE};
         free_ff      <= NONE;
         fill_ff      <= '0;
         time_ff      <= '0;
         quantum_ff   <= mlfq_pkg::QUANTUM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         fill_ff      <= fill_in;
         time_ff      <= time_in;
         quantum_ff   <= quantum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      band_ff       <= band_in;
      key_ff        <= key_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_level_ff  <= res_level_in;
      res_prio_ff   <= res_prio_in;
      res_left_ff   <= res_left_in;
      if (load_out) begin
         rsp_status_ff <= res_status_ff;
         rsp_run_id_ff <= res_id_ff;
         rsp_level_ff  <= res_level_ff;
         rsp_prio_ff   <= res_prio_ff;
         rsp_left_ff   <= res_left_ff;
         rsp_time_ff   <= time_ff;
      end
   end

   // entry table ports
   always_ff @(posedge clock) begin
      if (id_we) id_mem[idx_ff] <= id_wd;
      if (tab_we) begin
         prio_mem[idx_ff] <= prio_wd;
         rem_mem[idx_ff]  <= rem_wd;
      end
      if (next_we) next_mem[next_wa] <= next_wd;
      rd_id_ff   <= id_mem[rd_addr];
      rd_prio_ff <= prio_mem[rd_addr];
      rd_rem_ff  <= rem_mem[rd_addr];
      rd_next_ff <= next_mem[rd_addr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_run_id       = rsp_run_id_ff;
   assign rsp_level        = rsp_level_ff;
   assign rsp_new_priority = rsp_prio_ff;
   assign rsp_work_left    = rsp_left_ff;
   assign rsp_time_now     = rsp_time_ff;

   `MLFQ_ASSERT(a_pop_only_idle, clock, reset, item_pop |-> state_ff == mlfq_pkg::ST_IDLE)
   `MLFQ_ASSERT(a_beat_from_emit, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == mlfq_pkg::ST_EMIT)
   `MLFQ_ASSERT(a_fill_bound, clock, reset, fill_ff <= NONE)
   `MLFQ_ASSERT_ALWAYS(a_rt_head_tail, clock, reset || ((head_ff[0] == NONE) == (tail_ff[0] == NONE)))

endmodule

/* hw/rtl/multilevel_feedback_queue_scheduler_top.sv */
// Five-level feedback queue scheduler over a table of TABLE_ENTRIES process entries kept
// in linked lists. A two-beat input queue takes requests while the sequencer works, and a
// result register holds the finished beat while the next request is taken in. One request
// occupies the sequencer through decode, table access and, when it places an entry into a
// priority-ordered level, a walk past the entries ahead of it; the result may also wait on
// a stall. The walk reads one entry at a time through the single read port of the entry
// table. No clearing pass is needed after reset: unused entries are handed out by a fill
// counter.
module multilevel_feedback_queue_scheduler_top #(
   parameter int TABLE_ENTRIES = mlfq_pkg::TABLE_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_operation,
   input  logic [15:0]       req_process_id,
   input  logic signed [7:0] req_start_priority,
   input  logic [15:0]       req_burst_time,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [15:0]       rsp_run_id,
   output logic [2:0]        rsp_level,
   output logic signed [7:0] rsp_new_priority,
   output logic [15:0]       rsp_work_left,
   output logic [31:0]       rsp_time_now
);

   logic               item_valid;
   logic               item_pop;
   mlfq_pkg::item_type item;

   // request queue and classifier
   mlfq_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_process_id     (req_process_id),
      .req_start_priority (req_start_priority),
      .req_burst_time     (req_burst_time),
      .item_valid         (item_valid),
      .item               (item),
      .item_pop           (item_pop)
   );

   // table sequencer
   mlfq_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (item_valid),
      .item             (item),
      .item_pop         (item_pop),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_run_id       (rsp_run_id),
      .rsp_level        (rsp_level),
      .rsp_new_priority (rsp_new_priority),
      .rsp_work_left    (rsp_work_left),
      .rsp_time_now     (rsp_time_now)
   );

endmodule

/* dv/tb_multilevel_feedback_queue_scheduler_top.sv */
module tb_multilevel_feedback_queue_scheduler_top;

   localparam int NSLOT    = 64;
   localparam int NIL      = NSLOT;
   localparam int HANG_MAX = 200000;

   typedef struct {
      logic              op;
      logic [15:0]       id;
      logic signed [7:0] prio;
      logic [15:0]       burst;
   } sched_req_type;

   typedef struct {
      logic [2:0]        status;
      logic [15:0]       run_id;
      logic [2:0]        level;
      logic signed [7:0] prio;
      logic [15:0]       left;
      logic [31:0]       tnow;
   } sched_rsp_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_operation = 1'b0;
   logic [15:0]       req_process_id = '0;
   logic signed [7:0] req_start_priority = '0;
   logic [15:0]       req_burst_time = '0;
   logic              csr_we = 1'b0;
   logic [15:0]       csr_wdata = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [2:0]        rsp_status;
   logic [15:0]       rsp_run_id;
   logic [2:0]        rsp_level;
   logic signed [7:0] rsp_new_priority;
   logic [15:0]       rsp_work_left;
   logic [31:0]       rsp_time_now;

   multilevel_feedback_queue_scheduler_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_operation(req_operation),
      .req_process_id(req_process_id), .req_start_priority(req_start_priority),
      .req_burst_time(req_burst_time), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_run_id(rsp_run_id), .rsp_level(rsp_level),
      .rsp_new_priority(rsp_new_priority), .rsp_work_left(rsp_work_left),
      .rsp_time_now(rsp_time_now)
   );

   always #6 clock = ~clock;

   // scheduler shadow state
   logic [15:0]       sh_id    [NSLOT];
   int                sh_prio  [NSLOT];
   logic [15:0]       sh_left  [NSLOT];
   int                sh_next  [NSLOT];
   int                sh_head  [mlfq_pkg::LEVELS];
   int                sh_tail  [mlfq_pkg::LEVELS];
   int                sh_free;
   logic [31:0]       sh_clock;
   logic [15:0]       sh_quantum;

   sched_req_type pending_reqs[$];
   sched_rsp_type expected_rsps[$];
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   hang_count = 0;
   bit   failed = 0;
   logic req_fire = 1'b0;

   function automatic logic [2:0] level_for(int p);
      if (p >= -10 && p <= -1) return mlfq_pkg::LEVEL_RT;
      if (p >= 1 && p <= 10) return mlfq_pkg::LEVEL_LOW;
      if (p >= 11 && p <= 20) return mlfq_pkg::LEVEL_MID;
      if (p >= 21 && p <= 30) return mlfq_pkg::LEVEL_HIGH;
      return mlfq_pkg::LEVEL_RR;
   endfunction

   // link an entry into its level, sorted levels keep arrival order on ties
   function automatic void enqueue_slot(int s);
      int lv;
      int prv;
      int cur;
      lv = int'(level_for(sh_prio[s]));
      prv = NIL;
      cur = NIL;
      if (lv == mlfq_pkg::LEVEL_RT || lv == mlfq_pkg::LEVEL_RR) begin
         prv = sh_tail[lv];
      end else begin
         cur = sh_head[lv];
         while (cur != NIL && sh_prio[cur] <= sh_prio[s]) begin
            prv = cur;
            cur = sh_next[cur];
         end
      end
      sh_next[s] = cur;
      if (prv == NIL) sh_head[lv] = s;
      else sh_next[prv] = s;
      if (cur == NIL) sh_tail[lv] = s;
   endfunction

   function automatic void shadow_reset();
      for (int i = 0; i < NSLOT; i++) sh_next[i] = i + 1;
      for (int i = 0; i < mlfq_pkg::LEVELS; i++) begin
         sh_head[i] = NIL;
         sh_tail[i] = NIL;
      end
      sh_free = 0;
      sh_clock = '0;
      sh_quantum = mlfq_pkg::QUANTUM_RESET;
   endfunction

   // compute the result of one accepted beat
   function automatic sched_rsp_type schedule_step(sched_req_type r);
      sched_rsp_type o;
      int s;
      int lv;
      int p;
      o = '{default: '0};
      if (r.op == mlfq_pkg::OP_SUBMIT) begin
         o.run_id = r.id;
         o.level = level_for(r.prio);
         o.prio = r.prio;
         o.left = r.burst;
         if (sh_free == NIL) begin
            o.status = mlfq_pkg::STATUS_FULL;
         end else begin
            s = sh_free;
            sh_free = sh_next[s];
            sh_id[s] = r.id;
            sh_prio[s] = r.prio;
            sh_left[s] = r.burst;
            enqueue_slot(s);
            o.status = mlfq_pkg::STATUS_ACCEPTED;
         end
         o.tnow = sh_clock;
         return o;
      end
      lv = 0;
      while (lv < mlfq_pkg::LEVELS && sh_head[lv] == NIL) lv++;
      if (lv == mlfq_pkg::LEVELS) begin
         sh_clock = sh_clock + 32'd1;
         o.status = mlfq_pkg::STATUS_IDLE;
         o.tnow = sh_clock;
         return o;
      end
      s = sh_head[lv];
      sh_head[lv] = sh_next[s];
      if (sh_head[lv] == NIL) sh_tail[lv] = NIL;
      o.run_id = sh_id[s];
      o.level = 3'(lv);
      if (lv != mlfq_pkg::LEVEL_RT && sh_left[s] > sh_quantum) begin
         sh_clock = sh_clock + 32'(sh_quantum);
         sh_left[s] = sh_left[s] - sh_quantum;
         if (lv != mlfq_pkg::LEVEL_RR) begin
            p = sh_prio[s] + 10;
            sh_prio[s] = (p > 31) ? 31 : p;
         end
         enqueue_slot(s);
         o.status = mlfq_pkg::STATUS_PARTIAL;
         o.left = sh_left[s];
      end else begin
         sh_clock = sh_clock + 32'(sh_left[s]);
         sh_left[s] = '0;
         sh_next[s] = sh_free;
         sh_free = s;
         o.status = mlfq_pkg::STATUS_DONE;
         o.left = '0;
      end
      o.prio = 8'(sh_prio[s]);
      o.tnow = sh_clock;
      return o;
   endfunction

   // driver: new beat at falling edge once the last one was taken
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_fire) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_operation <= pending_reqs[0].op;
               req_process_id <= pending_reqs[0].id;
               req_start_priority <= pending_reqs[0].prio;
               req_burst_time <= pending_reqs[0].burst;
               void'(pending_reqs.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // monitor: predict on accepted request, check on accepted result
   always @(posedge clock) begin
      sched_req_type r;
      sched_rsp_type e;
      logic in_fire;
      logic out_fire;
      in_fire = req_valid && !req_stall;
      out_fire = rsp_valid && !rsp_stall;
      req_fire <= !reset && in_fire;
      if (!reset) begin
         if (in_fire || out_fire) hang_count <= 0;
         else hang_count <= hang_count + 1;
         if (in_fire) begin
            r.op = req_operation;
            r.id = req_process_id;
            r.prio = req_start_priority;
            r.burst = req_burst_time;
            expected_rsps.push_back(schedule_step(r));
         end
         if (out_fire) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result beat");
               failed = 1;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status exp %0d got %0d", e.status, rsp_status);
                  failed = 1;
               end
               if (rsp_run_id !== e.run_id) begin
                  $error("run_id exp %0d got %0d", e.run_id, rsp_run_id);
                  failed = 1;
               end
               if (rsp_level !== e.level) begin
                  $error("level exp %0d got %0d", e.level, rsp_level);
                  failed = 1;
               end
               if (rsp_new_priority !== e.prio) begin
                  $error("new_priority exp %0d got %0d", e.prio, rsp_new_priority);
                  failed = 1;
               end
               if (rsp_work_left !== e.left) begin
                  $error("work_left exp %0d got %0d", e.left, rsp_work_left);
                  failed = 1;
               end
               if (rsp_time_now !== e.tnow) begin
                  $error("time_now exp %0d got %0d", e.tnow, rsp_time_now);
                  failed = 1;
               end
            end
         end
      end
   end

   // watchdog on lack of progress
   always @(posedge clock) begin
      if (hang_count >= HANG_MAX) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic add_req(logic op, logic [15:0] id, logic signed [7:0] prio,
                          logic [15:0] burst);
      sched_req_type r;
      r.op = op;
      r.id = id;
      r.prio = prio;
      r.burst = burst;
      pending_reqs.push_back(r);
   endtask

   // wait for drain, then write the quantum while idle
   task automatic set_quantum(logic [15:0] q);
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (140) @(posedge clock);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= q;
      @(negedge clock);
      csr_we <= 1'b0;
      sh_quantum = q;
   endtask

   function automatic logic signed [7:0] pick_prio();
      case ($urandom_range(7))
         0: return 8'($urandom_range(10) - 10);
         1: return 8'($urandom_range(10) + 1);
         2: return 8'($urandom_range(10) + 11);
         3: return 8'($urandom_range(10) + 20);
         4: return 8'($urandom_range(5) + 29);
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // random phase: submits and dispatches mixed at random
   task automatic random_phase(int n, int burst_max);
      int k;
      k = 0;
      while (k < n) begin
         if ($urandom_range(99) < 45) begin
            add_req(mlfq_pkg::OP_SUBMIT, 16'($urandom), pick_prio(),
                    ($urandom_range(9) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(burst_max)));
         end else begin
            add_req(mlfq_pkg::OP_DISPATCH, 16'($urandom), 8'($urandom), 16'($urandom));
         end
         k++;
      end
   endtask

   initial begin
      shadow_reset();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle tick, every band edge, zero burst, real time, full table
      send_idle_pct = 28;
      recv_idle_pct = 63;
      add_req(mlfq_pkg::OP_DISPATCH, 16'hFFFF, 8'sh7F, 16'hFFFF);
      add_req(mlfq_pkg::OP_SUBMIT, 16'h0000, -8'sd10, 16'd0);
      add_req(mlfq_pkg::OP_SUBMIT, 16'hFFFF, -8'sd1, 16'hFFFF);
      add_req(mlfq_pkg::OP_SUBMIT, 16'h1234, 8'sd0, 16'd25);
      add_req(mlfq_pkg::OP_SUBMIT, 16'h0001, 8'sd1, 16'd35);
      add_req(mlfq_pkg::OP_SUBMIT, 16'h0002, 8'sd10, 16'd11);
      add_req(mlfq_pkg::OP_SUBMIT, 16'h0003, 8'sd11, 16'd10);
      add_req(mlfq_pkg::OP_SUBMIT, 16'h0004, 8'sd20, 16'd30);
      add_req(mlfq_pkg::OP_SUBMIT, 16'h0005, 8'sd21, 16'd40);
      add_req(mlfq_pkg::OP_SUBMIT, 16'h0006, 8'sd30, 16'd21);
      add_req(mlfq_pkg::OP_SUBMIT, 16'h0007, 8'sd31, 16'd1);
      add_req(mlfq_pkg::OP_SUBMIT, 16'h0008, -8'sd128, 16'd12);
      add_req(mlfq_pkg::OP_SUBMIT, 16'h0009, 8'sd127, 16'd5);
      add_req(mlfq_pkg::OP_SUBMIT, 16'h000A, -8'sd11, 16'd9);
      repeat (24) add_req(mlfq_pkg::OP_DISPATCH, '0, '0, '0);
      for (int i = 0; i < 66; i++)
         add_req(mlfq_pkg::OP_SUBMIT, 16'($urandom), pick_prio(),
                 16'($urandom_range(1, 40)));
      repeat (70) add_req(mlfq_pkg::OP_DISPATCH, '0, '0, '0);
      random_phase(350, 60);

      // zero quantum and the top extreme
      set_quantum(16'd0);
      add_req(mlfq_pkg::OP_SUBMIT, 16'h00AA, 8'sd5, 16'd3);
      add_req(mlfq_pkg::OP_SUBMIT, 16'h00AB, 8'sd0, 16'd0);
      repeat (6) add_req(mlfq_pkg::OP_DISPATCH, '0, '0, '0);
      set_quantum(16'hFFFF);
      repeat (6) add_req(mlfq_pkg::OP_DISPATCH, '0, '0, '0);
      random_phase(200, 65535);

      send_idle_pct = 63;
      recv_idle_pct = 28;
      set_quantum(16'd1);
      random_phase(400, 20);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_quantum(16'($urandom_range(2, 50)));
      random_phase(450, 200);

      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
      if (!failed && expected_rsps.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
